// ----- sv/ahc_pkg.sv -----
`default_nettype none

package ahc_pkg;

    // Coordinate format and CORDIC chain length.
    localparam int COORD_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int TABLE_LEN   = 24;
    localparam int STAGES      = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    // Field widths of the channels.
    localparam int OPERAND_W = 16;
    localparam int ANGLE_W   = 16;

    // Working registers: coordinates are scaled up into a 64-bit word.
    localparam int PRESCALE = 60 - COORD_WIDTH;
    localparam int WORK_W   = 64;

    // Angle accumulator in Q16 radians; 20 bits hold the widest sum.
    localparam int ZW = 20;

    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW-1:0] PI_Q13      = 20'sd25736;
    localparam logic signed [ZW-1:0] ROUND_HALF  = 20'sd4;

    // Input operation codes.
    localparam logic OP_STORE_X = 1'b0;
    localparam logic OP_EVAL_Y  = 1'b1;

    // atan(2^-i) in Q16, rounded to nearest.
    localparam logic [ZW-1:0] STEP_ANGLE [TABLE_LEN] = '{
        20'd51472, 20'd30386, 20'd16055, 20'd8150, 20'd4091, 20'd2047,
        20'd1024, 20'd512, 20'd256, 20'd128, 20'd64, 20'd32,
        20'd16, 20'd8, 20'd4, 20'd2, 20'd1, 20'd0,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
    };

    // One point of the vectoring chain.
    typedef struct packed {
        logic signed [WORK_W-1:0] x;
        logic signed [WORK_W-1:0] y;
        logic signed [ZW-1:0]     z;
        logic                     origin;
    } t_vec;

endpackage

`default_nettype wire

// ----- sv/ahc_if.sv -----
`default_nettype none

interface ahc_in_if import ahc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic signed [OPERAND_W-1:0] operand_value;

    modport source (output valid, output op, output operand_value, input ready);
    modport sink   (input valid, input op, input operand_value, output ready);
endinterface

interface ahc_out_if import ahc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

// ----- sv/ahc_prep.sv -----
`default_nettype none

module ahc_prep import ahc_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic                        i_op,
    input  wire logic signed [OPERAND_W-1:0] i_operand_value,
    output      logic                        o_valid,
    output      t_vec                        o_vec
);

    logic                          acc;
    logic signed [COORD_WIDTH-1:0] coord;
    logic signed [COORD_WIDTH-1:0] r_stored_x;
    logic signed [WORK_W-1:0]      xs;
    logic signed [WORK_W-1:0]      ys;
    t_vec                          n_vec;
    t_vec                          r_vec;
    logic                          r_valid;

    assign acc   = i_valid && i_adv;
    assign coord = i_operand_value[COORD_WIDTH-1:0];

    // Scale both coordinates into the working word.
    assign xs = $signed({{(WORK_W-COORD_WIDTH-PRESCALE){r_stored_x[COORD_WIDTH-1]}},
                         r_stored_x, {PRESCALE{1'b0}}});
    assign ys = $signed({{(WORK_W-COORD_WIDTH-PRESCALE){coord[COORD_WIDTH-1]}},
                         coord, {PRESCALE{1'b0}}});

    // A point in the left half plane is turned by a quarter turn first.
    always_comb begin
        n_vec.origin = (r_stored_x == '0) && (coord == '0);
        if (!xs[WORK_W-1]) begin
            n_vec.x = xs;
            n_vec.y = ys;
            n_vec.z = '0;
        end else if (!ys[WORK_W-1]) begin
            n_vec.x = ys;
            n_vec.y = -xs;
            n_vec.z = HALF_PI_Q16;
        end else begin
            n_vec.x = -ys;
            n_vec.y = xs;
            n_vec.z = -HALF_PI_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_x <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (acc && (i_op == OP_STORE_X)) begin
                r_stored_x <= coord;
            end
            if (i_adv) begin
                r_valid <= acc && (i_op == OP_EVAL_Y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

    a_store_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_op == OP_STORE_X)) |=> !r_valid)
        else $error("x store produced a pending evaluation");

endmodule

`default_nettype wire

// ----- sv/ahc_chain.sv -----
`default_nettype none

module ahc_chain import ahc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_valid,
    input  wire t_vec i_vec,
    output      logic o_valid,
    output      t_vec o_vec
);

    t_vec r_vec [STAGES];
    logic r_vld [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        t_vec cur;
        t_vec n_vec;
        logic cur_vld;
        logic signed [WORK_W-1:0] dx;
        logic signed [WORK_W-1:0] dy;

        if (k == 0) begin : g_first
            assign cur     = i_vec;
            assign cur_vld = i_valid;
        end else begin : g_next
            assign cur     = r_vec[k-1];
            assign cur_vld = r_vld[k-1];
        end

        assign dx = cur.y >>> k;
        assign dy = cur.x >>> k;

        // Rotate toward the x axis; the sign of y picks the direction.
        always_comb begin
            n_vec.origin = cur.origin;
            if (!cur.y[WORK_W-1]) begin
                n_vec.x = cur.x + dx;
                n_vec.y = cur.y - dy;
                n_vec.z = cur.z + $signed(STEP_ANGLE[k]);
            end else begin
                n_vec.x = cur.x - dx;
                n_vec.y = cur.y + dy;
                n_vec.z = cur.z - $signed(STEP_ANGLE[k]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_vec[k] <= n_vec;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_vec   = r_vec[STAGES-1];

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(o_valid) && (!o_valid || $stable(o_vec))))
        else $error("chain moved while stalled");

endmodule

`default_nettype wire

// ----- sv/ahc_post.sv -----
`default_nettype none

module ahc_post import ahc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire t_vec                      i_vec,
    output      logic                      o_valid,
    output      logic signed [ANGLE_W-1:0] o_angle
);

    logic signed [ZW-1:0]   q;
    logic signed [ZW-4:0]   rq;
    logic signed [ZW-1:0]   rq_ext;
    logic signed [ANGLE_W-1:0] n_angle;
    logic signed [ANGLE_W-1:0] r_angle;
    logic                      r_valid;

    // Round Q16 to Q13: add half an output step, then floor.
    assign q      = i_vec.z + ROUND_HALF;
    assign rq     = q[ZW-1:3];
    assign rq_ext = ZW'(rq);

    always_comb begin
        priority if (i_vec.origin) begin
            n_angle = '0;
        end else if (rq_ext > PI_Q13) begin
            n_angle = PI_Q13[ANGLE_W-1:0];
        end else if (rq_ext < -PI_Q13) begin
            n_angle = ANGLE_W'(-PI_Q13);
        end else begin
            n_angle = rq_ext[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_angle <= ANGLE_W'(PI_Q13)) && (r_angle >= ANGLE_W'(-PI_Q13))))
        else $error("angle outside of plus or minus pi");

endmodule

`default_nettype wire

// ----- sv/atan2_hot_cold_top.sv -----
`default_nettype none

// Two-argument arc tangent with a stored (cold) x and a streaming (hot) y.
//
// Input channel i_coord carries op and operand_value. An item with op 0
// stores operand_value as x and produces no result. An item with op 1
// carries y and produces one result item on o_angle: atan2(y, x) in
// radians, Q3.13, from -pi to +pi, with the origin giving 0.
//
// The angle comes from a pipelined CORDIC vectoring chain, one register
// stage per shift-add iteration. The input register loads at the accepting
// edge; the result then passes through one stage per iteration and the
// output register before it is valid. Throughput is one item per cycle
// while o_angle is not stalled, set by one iteration per stage.
//
// Reset clears all valid bits and sets the stored x to zero. When the
// receiver holds o_angle.ready low with a result waiting, the whole
// pipeline freezes and i_coord.ready drops; items already in flight are
// kept and nothing is lost or repeated.
module atan2_hot_cold_top import ahc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ahc_in_if.sink     i_coord,
    ahc_out_if.source  o_angle
);

    logic adv;
    logic prep_valid;
    t_vec prep_vec;
    logic chain_valid;
    t_vec chain_vec;

    // The pipeline moves whenever the output register is free or being
    // emptied this cycle.
    assign adv           = !o_angle.valid || o_angle.ready;
    assign i_coord.ready = adv;

    // Input register, x storage and quarter-turn preparation.
    ahc_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_valid         (i_coord.valid),
        .i_op            (i_coord.op),
        .i_operand_value (i_coord.operand_value),
        .o_valid         (prep_valid),
        .o_vec           (prep_vec)
    );

    // Shift-add iterations, one per pipeline stage.
    ahc_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (prep_valid),
        .i_vec   (prep_vec),
        .o_valid (chain_valid),
        .o_vec   (chain_vec)
    );

    // Rounding, saturation and the result register.
    ahc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (chain_valid),
        .i_vec   (chain_vec),
        .o_valid (o_angle.valid),
        .o_angle (o_angle.angle)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_angle.valid && !o_angle.ready) |-> !i_coord.ready)
        else $error("input accepted while the result is stalled");

endmodule

`default_nettype wire
